// ----- src/keyboard_hid_report_builder_defines.svh -----
// ============================================================================
// Assertion macros for the keyboard HID report builder
// Shared concurrent assertion forms; clocked on clk, disabled during arst_n.
// ============================================================================
`ifndef KEYBOARD_HID_REPORT_BUILDER_DEFINES_SVH
`define KEYBOARD_HID_REPORT_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KHRB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define KHRB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KHRB_ASSERT_IMP(lbl, ante, cons, msg)
`define KHRB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/khrb_pkg.sv -----
// ============================================================================
// khrb_pkg
// Types and constants of the keyboard HID report builder.
// ============================================================================
package khrb_pkg;

	localparam int KEY_COUNT   = 52;
	localparam int LAYER_COUNT = 3;
	localparam int SLOT_COUNT  = 6;

	// fixed report / register file shape
	localparam int MAX_SLOTS  = 6;
	localparam int LAYER_REGS = 3;

	localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int LAYER_IDX_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
	localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int KEY_NUM_W  = 6;
	localparam int MAP_LYR_W  = 2;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER2 = 2'd2;

	localparam logic [7:0] LAYER0_RST = 8'd0;
	localparam logic [7:0] LAYER1_RST = 8'd1;
	localparam logic [7:0] LAYER2_RST = 8'd2;

	// toggle byte value that marks a toggle key
	localparam logic [7:0] TOGGLE_MARK = 8'd1;

	// action codes
	localparam logic ACT_KEY = 1'b0;
	localparam logic ACT_MAP = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [KEY_NUM_W-1:0] key_number;
		logic                 pressed;
		logic                 scan_start;
		logic [MAP_LYR_W-1:0] map_layer;
		logic [WORD_W-1:0]    map_word;
	} khrb_in_t;

	typedef struct packed {
		logic [7:0] modifiers;
		logic [7:0] slot_one;
		logic [7:0] slot_two;
		logic [7:0] slot_three;
		logic [7:0] slot_four;
		logic [7:0] slot_five;
		logic [7:0] slot_six;
		logic [7:0] layer_bits;
	} khrb_out_t;

	// per-key record payload, kept in RAM
	typedef struct packed {
		logic                  has_slot;
		logic [SLOT_IDX_W-1:0] slot;
		logic [7:0]            mods;
		logic [7:0]            layer;
	} khrb_rec_t;

	typedef struct packed {
		logic                 we;
		logic [KEY_IDX_W-1:0] addr;
		khrb_rec_t            data;
	} khrb_rec_wr_t;

	// item handed to the engine in the processing cycle
	typedef struct packed {
		logic                 go;
		logic                 action;
		logic [KEY_NUM_W-1:0] key;
		logic                 pressed;
		logic                 scan;
	} khrb_step_t;

endpackage

// ----- src/keyboard_hid_report_builder.sv -----
// ============================================================================
// keyboard_hid_report_builder: an accepted item passes the registered RAM read
// into stage 1, then the report register, which raises report_valid.
// Throughput: one transaction per cycle; a stalled report holds one item in stage 1.
// Async reset: key state, report_valid cleared, layer regs preset; keymap undefined.
// ============================================================================
`include "keyboard_hid_report_builder_defines.svh"

// Structure
//   acceptance edge : keymap words of all layers and the key record are read
//                     from RAM at the item's key number; keymap writes are done
//                     here too, so a following item always sees them.
//   stage 1         : item waits in *_s1 with the RAM data. The engine
//                     translates the layer, picks the keymap word of the active
//                     layer, runs the press/release update and loads the
//                     report register in the same edge.
//   report register : holds the finished report until the sink takes it; the
//                     next item can already sit in stage 1 behind it.
// Record bypass: the engine may write a key's record in the very edge in which
// the next item reads that key's record; the written value is caught in
// fwd_rec_s1 and used instead of the stale RAM data.
// No clearing pass: keymap words are undefined until written, and key records
// are qualified by per-key valid flops in the engine.

module keyboard_hid_report_builder
	import khrb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                  item_valid,
	output logic                  item_ready,
	input  khrb_in_t              item,
	// result reports
	output logic                  report_valid,
	input  logic                  report_ready,
	output khrb_out_t             report
);

	logic                 accept;
	logic                 go;
	logic                 in_key_ok;
	logic [KEY_IDX_W-1:0] in_kidx;

	logic                 valid_s1;
	logic                 action_s1;
	logic [KEY_NUM_W-1:0] key_s1;
	logic                 pressed_s1;
	logic                 scan_s1;
	logic                 fwd_hit_s1;
	khrb_rec_t            fwd_rec_s1;

	logic [WORD_W-1:0]    kmap_word [LAYER_COUNT];
	khrb_rec_t            rec_rd_raw;
	khrb_rec_t            rec_rd;
	khrb_rec_wr_t         rec_wr;
	khrb_step_t           step;
	khrb_out_t            next_report;

	logic                 report_valid_q;
	khrb_out_t            report_q;

	// handshake: stage 1 drains whenever the report register is free or leaving
	assign go         = valid_s1 && (!report_valid_q || report_ready);
	assign item_ready = !valid_s1 || go;
	assign accept     = item_valid && item_ready;

	assign in_key_ok = (int'(item.key_number) < KEY_COUNT);
	assign in_kidx   = item.key_number[KEY_IDX_W-1:0];

	// keymap, one RAM per layer, all read at the item's key
	for (genvar l = 0; l < LAYER_COUNT; l++) begin : g_kmap
		khrb_ram #(
			.WIDTH (WORD_W),
			.DEPTH (KEY_COUNT)
		) u_kmap (
			.clk   (clk),
			.we    (accept && item.action == ACT_MAP && in_key_ok &&
			        item.map_layer == MAP_LYR_W'(l)),
			.waddr (in_kidx),
			.wdata (item.map_word),
			.re    (accept),
			.raddr (in_kidx),
			.rdata (kmap_word[l])
		);
	end

	// held-key records
	khrb_ram #(
		.WIDTH ($bits(khrb_rec_t)),
		.DEPTH (KEY_COUNT)
	) u_rec (
		.clk   (clk),
		.we    (rec_wr.we),
		.waddr (rec_wr.addr),
		.wdata (rec_wr.data),
		.re    (accept),
		.raddr (in_kidx),
		.rdata (rec_rd_raw)
	);

	assign rec_rd = fwd_hit_s1 ? fwd_rec_s1 : rec_rd_raw;

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			fwd_hit_s1 <= rec_wr.we && (rec_wr.addr == in_kidx);
		end else if (go) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= item.action;
			key_s1     <= item.key_number;
			pressed_s1 <= item.pressed;
			scan_s1    <= item.scan_start;
			fwd_rec_s1 <= rec_wr.data;
		end
	end

	assign step.go      = go;
	assign step.action  = action_s1;
	assign step.key     = key_s1;
	assign step.pressed = pressed_s1;
	assign step.scan    = scan_s1;

	khrb_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.step        (step),
		.kmap_word   (kmap_word),
		.rec_rd      (rec_rd),
		.rec_wr      (rec_wr),
		.next_report (next_report)
	);

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (go) begin
			report_valid_q <= 1'b1;
		end else if (report_ready) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			report_q <= next_report;
		end
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

	// an accepted transaction always lands in stage 1
	`KHRB_ASSERT_NXT(a_accept_lands, accept, valid_s1, "accepted item lost")
	// a processed item always leaves a report behind
	`KHRB_ASSERT_NXT(a_go_reports, go, report_valid_q, "processed item gave no report")

endmodule

// ----- src/khrb_ram.sv -----
// ============================================================================
// khrb_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module khrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/khrb_engine.sv -----
// ============================================================================
// khrb_engine
// Report state, layer translation and per-key press/release update.
// ============================================================================
`include "keyboard_hid_report_builder_defines.svh"

module khrb_engine
	import khrb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  khrb_step_t            step,
	input  logic [WORD_W-1:0]     kmap_word [LAYER_COUNT],
	input  khrb_rec_t             rec_rd,
	output khrb_rec_wr_t          rec_wr,
	output khrb_out_t             next_report
);

	logic [7:0]             layer_reg_q [LAYER_REGS];
	logic [7:0]             slots_q [SLOT_COUNT];
	logic [7:0]             n_slots [SLOT_COUNT];
	logic [7:0]             full_slots [MAX_SLOTS];
	logic [7:0]             mods_q, n_mods;
	logic [7:0]             layer_q, n_layer;
	logic [LAYER_IDX_W-1:0] al_q, al;
	logic [KEY_COUNT-1:0]   in_use_q, n_in_use;
	logic [KEY_COUNT-1:0]   rec_valid_q, n_rec_valid;
	logic [KEY_COUNT-1:0]   toggle_q, n_toggle;
	logic [WORD_W-1:0]      word;
	logic [7:0]             code;
	logic                   free_found;
	logic [SLOT_IDX_W-1:0]  free_idx;
	logic                   key_ok;
	logic [KEY_IDX_W-1:0]   kidx;

	always_comb begin
		// layer translation: last matching register wins
		al = al_q;
		if (step.scan) begin
			for (int i = 0; i < LAYER_REGS; i++) begin
				if (i < LAYER_COUNT && layer_reg_q[i] == layer_q) begin
					al = LAYER_IDX_W'(i);
				end
			end
		end
		word = kmap_word[al];
		code = word[7:0];

		// first empty slot
		free_found = 1'b0;
		free_idx   = '0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			if (!free_found && slots_q[s] == 8'd0) begin
				free_found = 1'b1;
				free_idx   = SLOT_IDX_W'(s);
			end
		end

		key_ok = (int'(step.key) < KEY_COUNT);
		kidx   = step.key[KEY_IDX_W-1:0];

		n_slots     = slots_q;
		n_mods      = mods_q;
		n_layer     = layer_q;
		n_in_use    = in_use_q;
		n_rec_valid = rec_valid_q;
		n_toggle    = toggle_q;
		rec_wr      = '0;

		if (step.go && step.action == ACT_KEY && key_ok) begin
			if (step.pressed && !in_use_q[kidx]) begin
				if (rec_valid_q[kidx]) begin
					// second press of a toggle key: report untouched
					n_in_use[kidx] = 1'b1;
					n_toggle[kidx] = 1'b0;
				end else if (code == 8'd0 || free_found) begin
					if (code != 8'd0) begin
						n_slots[free_idx] = code;
					end
					n_rec_valid[kidx]      = 1'b1;
					n_toggle[kidx]         = (word[31:24] == TOGGLE_MARK);
					n_in_use[kidx]         = 1'b1;
					n_mods                 = mods_q | word[15:8];
					n_layer                = layer_q | word[23:16];
					rec_wr.we              = 1'b1;
					rec_wr.addr            = kidx;
					rec_wr.data.has_slot   = (code != 8'd0);
					rec_wr.data.slot       = (code != 8'd0) ? free_idx : '0;
					rec_wr.data.mods       = word[15:8];
					rec_wr.data.layer      = word[23:16];
				end
				// report full: key stays not in use
			end else if (!step.pressed && in_use_q[kidx]) begin
				if (rec_valid_q[kidx] && toggle_q[kidx]) begin
					n_in_use[kidx] = 1'b0;
				end else begin
					if (rec_valid_q[kidx]) begin
						if (rec_rd.has_slot) begin
							n_slots[rec_rd.slot] = 8'd0;
						end
						n_mods  = mods_q ^ rec_rd.mods;
						n_layer = layer_q ^ rec_rd.layer;
					end
					n_rec_valid[kidx] = 1'b0;
					n_in_use[kidx]    = 1'b0;
				end
			end
		end

		for (int s = 0; s < MAX_SLOTS; s++) begin
			full_slots[s] = 8'd0;
		end
		for (int s = 0; s < SLOT_COUNT; s++) begin
			full_slots[s] = n_slots[s];
		end

		next_report.modifiers  = n_mods;
		next_report.slot_one   = full_slots[0];
		next_report.slot_two   = full_slots[1];
		next_report.slot_three = full_slots[2];
		next_report.slot_four  = full_slots[3];
		next_report.slot_five  = full_slots[4];
		next_report.slot_six   = full_slots[5];
		next_report.layer_bits = n_layer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_reg_q[0] <= LAYER0_RST;
			layer_reg_q[1] <= LAYER1_RST;
			layer_reg_q[2] <= LAYER2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LAYER0: layer_reg_q[0] <= cfg_data;
				CFG_LAYER1: layer_reg_q[1] <= cfg_data;
				CFG_LAYER2: layer_reg_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				slots_q[s] <= 8'd0;
			end
			mods_q      <= '0;
			layer_q     <= '0;
			al_q        <= '0;
			in_use_q    <= '0;
			rec_valid_q <= '0;
			toggle_q    <= '0;
		end else if (step.go) begin
			slots_q     <= n_slots;
			mods_q      <= n_mods;
			layer_q     <= n_layer;
			al_q        <= al;
			in_use_q    <= n_in_use;
			rec_valid_q <= n_rec_valid;
			toggle_q    <= n_toggle;
		end
	end

	// a key in use always owns a record
	`KHRB_ASSERT_IMP(a_use_has_rec, 1'b1, (in_use_q & ~rec_valid_q) == '0, "key in use without record")
	// a held record with key released is only a latched toggle
	`KHRB_ASSERT_IMP(a_idle_rec_toggle, 1'b1, (rec_valid_q & ~in_use_q & ~toggle_q) == '0, "stale record")
	// report bytes only move when an item is processed
	`KHRB_ASSERT_NXT(a_idle_stable, !step.go, $stable(mods_q) && $stable(layer_q), "report moved while idle")

endmodule
